// File: sv/csp_pkg.sv
package csp_pkg;

  localparam int CODE_W = 8;
  localparam int DBM_W  = 9;
  localparam int PCT_W  = 7;
  localparam int DEN_W  = DBM_W + 1;
  localparam int NUM_W  = 16;
  localparam int REM_W  = NUM_W + 1;
  localparam int Q_SPLIT = 3;

  localparam logic [CODE_W-1:0] RSSI_TOP  = 8'd31;
  localparam logic [CODE_W-1:0] RSCP_TOP  = 8'd96;
  localparam logic [CODE_W-1:0] RSRP_LOW  = 8'd44;
  localparam logic [CODE_W-1:0] RSRP_HIGH = 8'd140;

  localparam logic signed [DBM_W-1:0] RSSI_BASE     = -9'sd113;
  localparam logic signed [DBM_W-1:0] RSCP_BASE     = -9'sd120;
  localparam logic signed [DBM_W-1:0] NO_SIGNAL_DBM = -9'sd140;
  localparam logic signed [DBM_W-1:0] WEAK_RESET    = -9'sd100;
  localparam logic signed [DBM_W-1:0] STRONG_RESET  = -9'sd60;

  localparam logic [PCT_W-1:0] PCT_MIN = 7'd1;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  localparam logic CFG_WEAK   = 1'b0;
  localparam logic CFG_STRONG = 1'b1;

  typedef enum logic [1:0] {
    USED_RSSI,
    USED_RSCP,
    USED_RSRP,
    USED_NONE
  } csp_used_t;

  typedef struct packed {
    logic [CODE_W-1:0] gsm_rssi;
    logic [CODE_W-1:0] lte_rssi;
    logic [CODE_W-1:0] lte_rsrp;
    logic              wcdma_present;
    logic [CODE_W-1:0] wcdma_rssi;
    logic [CODE_W-1:0] wcdma_rscp;
    logic              tdscdma_present;
    logic [CODE_W-1:0] tdscdma_rssi;
    logic [CODE_W-1:0] tdscdma_rscp;
  } csp_report_t;

  typedef struct packed {
    logic signed [DBM_W-1:0] dbm;
    csp_used_t               used;
  } csp_meas_t;

  typedef struct packed {
    csp_meas_t         meas;
    logic [NUM_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [PCT_W-1:0]  q;
    logic              at_weak;
    logic              at_strong;
  } csp_div_t;

  typedef struct packed {
    logic signed [DBM_W-1:0] dbm;
    logic [PCT_W-1:0]        pct;
    csp_used_t               used;
  } csp_result_t;

endpackage

// File: sv/csp_if.sv
interface csp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] gsm_rssi;
  logic [7:0] lte_rssi;
  logic [7:0] lte_rsrp;
  logic       wcdma_present;
  logic [7:0] wcdma_rssi;
  logic [7:0] wcdma_rscp;
  logic       tdscdma_present;
  logic [7:0] tdscdma_rssi;
  logic [7:0] tdscdma_rscp;

  modport source (
    output valid, gsm_rssi, lte_rssi, lte_rsrp, wcdma_present, wcdma_rssi,
           wcdma_rscp, tdscdma_present, tdscdma_rssi, tdscdma_rscp,
    input  ready
  );
  modport sink (
    input  valid, gsm_rssi, lte_rssi, lte_rsrp, wcdma_present, wcdma_rssi,
           wcdma_rscp, tdscdma_present, tdscdma_rssi, tdscdma_rscp,
    output ready
  );
endinterface

interface csp_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] strength_dbm;
  logic [6:0]        strength_percent;
  logic [1:0]        measure_used;

  modport source (
    output valid, strength_dbm, strength_percent, measure_used,
    input  ready
  );
  modport sink (
    input  valid, strength_dbm, strength_percent, measure_used,
    output ready
  );
endinterface

// File: sv/csp_select.sv
module csp_select (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                valid_i,
  input  csp_pkg::csp_report_t rpt_i,
  output logic                valid_o,
  output csp_pkg::csp_meas_t  meas_o
);
  import csp_pkg::*;

  logic [3:0][CODE_W-1:0] rssi_code;
  logic [3:0]             rssi_en;
  logic [4:0]             rssi_best;
  logic                   rssi_any;
  logic [6:0]             rscp_best;
  logic                   rscp_any;
  logic                   w_ok;
  logic                   t_ok;
  logic                   rsrp_ok;
  csp_meas_t              meas_nxt;
  csp_meas_t              meas_r;
  logic                   valid_r;

  assign rssi_code = {rpt_i.tdscdma_rssi, rpt_i.wcdma_rssi, rpt_i.lte_rssi, rpt_i.gsm_rssi};
  assign rssi_en   = {rpt_i.tdscdma_present, rpt_i.wcdma_present, 2'b11};

  always_comb begin
    rssi_any  = 1'b0;
    rssi_best = '0;
    for (int i = 0; i < 4; i++) begin
      if (rssi_en[i] && rssi_code[i] <= RSSI_TOP &&
          (!rssi_any || rssi_code[i][4:0] > rssi_best)) begin
        rssi_any  = 1'b1;
        rssi_best = rssi_code[i][4:0];
      end
    end
  end

  assign w_ok    = rpt_i.wcdma_present && rpt_i.wcdma_rscp <= RSCP_TOP;
  assign t_ok    = rpt_i.tdscdma_present && rpt_i.tdscdma_rscp <= RSCP_TOP;
  assign rsrp_ok = rpt_i.lte_rsrp >= RSRP_LOW && rpt_i.lte_rsrp <= RSRP_HIGH;

  always_comb begin
    rscp_any  = w_ok || t_ok;
    rscp_best = '0;
    if (w_ok && t_ok) begin
      rscp_best = (rpt_i.wcdma_rscp > rpt_i.tdscdma_rscp) ? rpt_i.wcdma_rscp[6:0]
                                                           : rpt_i.tdscdma_rscp[6:0];
    end else if (w_ok) begin
      rscp_best = rpt_i.wcdma_rscp[6:0];
    end else if (t_ok) begin
      rscp_best = rpt_i.tdscdma_rscp[6:0];
    end
  end

  always_comb begin
    if (rssi_any) begin
      meas_nxt.dbm  = RSSI_BASE + $signed({3'b000, rssi_best, 1'b0});
      meas_nxt.used = USED_RSSI;
    end else if (rscp_any) begin
      meas_nxt.dbm  = RSCP_BASE + $signed({2'b00, rscp_best});
      meas_nxt.used = USED_RSCP;
    end else if (rsrp_ok) begin
      meas_nxt.dbm  = 9'sd0 - $signed({1'b0, rpt_i.lte_rsrp});
      meas_nxt.used = USED_RSRP;
    end else begin
      meas_nxt.dbm  = NO_SIGNAL_DBM;
      meas_nxt.used = USED_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meas_r <= meas_nxt;
    end
  end

  assign valid_o = valid_r;
  assign meas_o  = meas_r;

endmodule

// File: sv/csp_scale.sv
module csp_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          valid_i,
  input  csp_pkg::csp_meas_t            meas_i,
  input  logic signed [csp_pkg::DBM_W-1:0] weak_i,
  input  logic signed [csp_pkg::DBM_W-1:0] strong_i,
  output logic                          valid_o,
  output csp_pkg::csp_div_t             div_o
);
  import csp_pkg::*;

  logic signed [DEN_W-1:0] diff;
  logic signed [DEN_W-1:0] span;
  csp_div_t                div_nxt;
  csp_div_t                div_r;
  logic                    valid_r;

  assign diff = DEN_W'(meas_i.dbm) - DEN_W'(weak_i);
  assign span = DEN_W'(strong_i) - DEN_W'(weak_i);

  always_comb begin
    div_nxt.meas      = meas_i;
    div_nxt.rem       = {7'b0, diff[8:0]} * NUM_W'(PCT_MAX);
    div_nxt.den       = span;
    div_nxt.q         = '0;
    div_nxt.at_weak   = diff <= 10'sd0;
    div_nxt.at_strong = meas_i.dbm >= strong_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_r <= div_nxt;
    end
  end

  assign valid_o = valid_r;
  assign div_o   = div_r;

endmodule

// File: sv/csp_div.sv
module csp_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 valid_i,
  input  csp_pkg::csp_div_t    div_i,
  output logic                 valid_o,
  output csp_pkg::csp_result_t res_o
);
  import csp_pkg::*;

  csp_div_t         hi_nxt;
  csp_div_t         hi_r;
  csp_div_t         lo_full;
  csp_result_t      res_nxt;
  csp_result_t      res_r;
  logic             hi_valid_r;
  logic             res_valid_r;
  logic [REM_W-1:0] trial_hi;
  logic [REM_W-1:0] trial_lo;

  // quotient bits 6..3
  always_comb begin
    hi_nxt   = div_i;
    trial_hi = '0;
    for (int k = PCT_W - 1; k >= Q_SPLIT; k--) begin
      trial_hi = {1'b0, hi_nxt.rem} - ({7'b0, hi_nxt.den} << k);
      if (!trial_hi[REM_W-1]) begin
        hi_nxt.rem  = trial_hi[NUM_W-1:0];
        hi_nxt.q[k] = 1'b1;
      end
    end
  end

  // quotient bits 2..0
  always_comb begin
    lo_full  = hi_r;
    trial_lo = '0;
    for (int k = Q_SPLIT - 1; k >= 0; k--) begin
      trial_lo = {1'b0, lo_full.rem} - ({7'b0, lo_full.den} << k);
      if (!trial_lo[REM_W-1]) begin
        lo_full.rem  = trial_lo[NUM_W-1:0];
        lo_full.q[k] = 1'b1;
      end
    end
  end

  always_comb begin
    res_nxt.dbm  = lo_full.meas.dbm;
    res_nxt.used = lo_full.meas.used;
    if (lo_full.at_weak) begin
      res_nxt.pct = PCT_MIN;
    end else if (lo_full.at_strong) begin
      res_nxt.pct = PCT_MAX;
    end else begin
      res_nxt.pct = lo_full.q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else if (adv) begin
      hi_valid_r  <= valid_i;
      res_valid_r <= hi_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hi_r  <= hi_nxt;
      res_r <= res_nxt;
    end
  end

  assign valid_o = res_valid_r;
  assign res_o   = res_r;

endmodule

// File: sv/cellular_signal_strength_percent.sv
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    radio report (RSSI, RSCP, RSRP codes, present bits)
// out_ch   out  valid/ready    strength_dbm, strength_percent, measure_used
// cfg_*    in   cfg_we         cfg_idx selects weak/strong threshold, cfg_data 9 bits
//
// Four register stages: measure select, threshold compare and scale,
// then two divider stages (four and three quotient bits).
// One request per cycle unless out_ch stalls.
// Synchronous active-low reset empties the pipe and restores -100/-60 dBm.
// A stall on out_ch freezes every stage; in_ch.ready drops only while the
// last stage holds a result that is not taken.
module cellular_signal_strength_percent (
  input  logic                       clk,
  input  logic                       rst_n,
  csp_in_if.sink                     in_ch,
  csp_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic                       cfg_idx,
  input  logic [csp_pkg::DBM_W-1:0]  cfg_data
);
  import csp_pkg::*;

  logic signed [DBM_W-1:0] weak_r;
  logic signed [DBM_W-1:0] weak_nxt;
  logic signed [DBM_W-1:0] strong_r;
  logic signed [DBM_W-1:0] strong_nxt;
  logic                    adv;
  csp_report_t             rpt;
  logic                    s1_valid;
  csp_meas_t               s1_meas;
  logic                    s2_valid;
  csp_div_t                s2_div;
  logic                    s4_valid;
  csp_result_t             s4_res;

  always_comb begin
    weak_nxt   = weak_r;
    strong_nxt = strong_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_WEAK:   weak_nxt   = $signed(cfg_data);
        CFG_STRONG: strong_nxt = $signed(cfg_data);
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weak_r   <= WEAK_RESET;
      strong_r <= STRONG_RESET;
    end else begin
      weak_r   <= weak_nxt;
      strong_r <= strong_nxt;
    end
  end

  assign adv         = out_ch.ready || !s4_valid;
  assign in_ch.ready = adv;

  assign rpt.gsm_rssi        = in_ch.gsm_rssi;
  assign rpt.lte_rssi        = in_ch.lte_rssi;
  assign rpt.lte_rsrp        = in_ch.lte_rsrp;
  assign rpt.wcdma_present   = in_ch.wcdma_present;
  assign rpt.wcdma_rssi      = in_ch.wcdma_rssi;
  assign rpt.wcdma_rscp      = in_ch.wcdma_rscp;
  assign rpt.tdscdma_present = in_ch.tdscdma_present;
  assign rpt.tdscdma_rssi    = in_ch.tdscdma_rssi;
  assign rpt.tdscdma_rscp    = in_ch.tdscdma_rscp;

  csp_select u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (in_ch.valid),
    .rpt_i   (rpt),
    .valid_o (s1_valid),
    .meas_o  (s1_meas)
  );

  csp_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .valid_i  (s1_valid),
    .meas_i   (s1_meas),
    .weak_i   (weak_r),
    .strong_i (strong_r),
    .valid_o  (s2_valid),
    .div_o    (s2_div)
  );

  csp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (s2_valid),
    .div_i   (s2_div),
    .valid_o (s4_valid),
    .res_o   (s4_res)
  );

  assign out_ch.valid            = s4_valid;
  assign out_ch.strength_dbm     = s4_res.dbm;
  assign out_ch.strength_percent = s4_res.pct;
  assign out_ch.measure_used     = s4_res.used;

`ifndef SYNTHESIS
  a_none_dbm: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.measure_used == USED_NONE |-> out_ch.strength_dbm == NO_SIGNAL_DBM)
    else $error("no-signal result without -140 dBm");

  a_rssi_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.measure_used == USED_RSSI |-> out_ch.strength_dbm[0])
    else $error("RSSI-derived level not odd");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.strength_percent <= PCT_MAX)
    else $error("percent above 100");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid && !adv |=> s2_valid && $stable(s2_div))
    else $error("mid-pipe request lost during stall");
`endif

endmodule

// File: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import csp_pkg::*;

  localparam int                PHASES         = 9;
  localparam int                PHASE_REPORTS  = 155;
  localparam int                SQUEEZE_PHASE  = 3;
  localparam int                STALL_LIMIT    = 3000;
  localparam int                DRAIN_CYCLES   = 8;
  localparam logic [CODE_W-1:0] NO_CODE        = 8'hFF;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic                    cfg_idx;
  logic [DBM_W-1:0]        cfg_data;

  csp_in_if  in_ch ();
  csp_out_if out_ch ();

  cellular_signal_strength_percent i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  csp_report_t             report_backlog [$];
  csp_result_t             strength_due [$];
  csp_report_t             on_offer;
  bit                      offer_open;
  logic signed [DBM_W-1:0] weak_thr;
  logic signed [DBM_W-1:0] strong_thr;
  bit                      src_calm;
  bit                      sink_calm;
  bit                      squeeze_req;
  int                      src_gap;
  int                      sink_hold;
  int                      stall_cycles;
  int                      mismatch_count;

  function automatic int keep_best(int best, logic [CODE_W-1:0] code, logic [CODE_W-1:0] top);
    if (code <= top && int'(code) > best) return int'(code);
    return best;
  endfunction

  function automatic csp_result_t predict_strength(csp_report_t r,
                                                   logic signed [DBM_W-1:0] weak_lvl,
                                                   logic signed [DBM_W-1:0] strong_lvl);
    int          rssi_best;
    int          rscp_best;
    int          lvl;
    int          lo;
    int          hi;
    int          pct;
    csp_result_t res;
    rssi_best = keep_best(-1, r.gsm_rssi, RSSI_TOP);
    rssi_best = keep_best(rssi_best, r.lte_rssi, RSSI_TOP);
    rscp_best = -1;
    if (r.wcdma_present) begin
      rssi_best = keep_best(rssi_best, r.wcdma_rssi, RSSI_TOP);
      rscp_best = keep_best(rscp_best, r.wcdma_rscp, RSCP_TOP);
    end
    if (r.tdscdma_present) begin
      rssi_best = keep_best(rssi_best, r.tdscdma_rssi, RSSI_TOP);
      rscp_best = keep_best(rscp_best, r.tdscdma_rscp, RSCP_TOP);
    end
    if (rssi_best >= 0) begin
      lvl = int'(RSSI_BASE) + 2 * rssi_best;
      res.used = USED_RSSI;
    end else if (rscp_best >= 0) begin
      lvl = int'(RSCP_BASE) + rscp_best;
      res.used = USED_RSCP;
    end else if (r.lte_rsrp >= RSRP_LOW && r.lte_rsrp <= RSRP_HIGH) begin
      lvl = -int'(r.lte_rsrp);
      res.used = USED_RSRP;
    end else begin
      lvl = int'(NO_SIGNAL_DBM);
      res.used = USED_NONE;
    end
    lo = weak_lvl;
    hi = strong_lvl;
    if (lvl <= lo) pct = 1;
    else if (lvl >= hi) pct = 100;
    else pct = (100 * (lvl - lo)) / (hi - lo);
    res.dbm = lvl[DBM_W-1:0];
    res.pct = pct[PCT_W-1:0];
    return res;
  endfunction

  function automatic csp_report_t mk_report(logic [7:0] g, l, rp, bit wp, logic [7:0] wr, wc,
                                            bit tp, logic [7:0] tr, tc);
    csp_report_t r;
    r.gsm_rssi        = g;
    r.lte_rssi        = l;
    r.lte_rsrp        = rp;
    r.wcdma_present   = wp;
    r.wcdma_rssi      = wr;
    r.wcdma_rscp      = wc;
    r.tdscdma_present = tp;
    r.tdscdma_rssi    = tr;
    r.tdscdma_rscp    = tc;
    return r;
  endfunction

  // valid codes lean on the range ends; invalid ones on the first code past the top and on 255
  function automatic logic [7:0] pick_code(int lo, int hi, bit ok);
    int r;
    int v;
    r = $urandom_range(0, 7);
    if (ok) v = (r == 0) ? lo : (r == 1) ? hi : $urandom_range(lo, hi);
    else if (lo > 0 && r < 3) v = $urandom_range(0, lo - 1);
    else if (r == 3) v = hi + 1;
    else if (r == 4) v = 255;
    else v = $urandom_range(hi + 1, 255);
    return v[7:0];
  endfunction

  // tier: 0 an RSSI wins, 1 an RSCP wins, 2 RSRP wins, 3 nothing valid
  function automatic csp_report_t rand_report();
    logic [63:0] raw;
    csp_report_t r;
    int          tier;
    int          pick;
    raw = {$urandom, $urandom};
    r = raw[$bits(csp_report_t)-1:0];
    tier = $urandom_range(0, 9);
    if (tier < 2) return r;
    tier = (tier < 6) ? 0 : (tier < 8) ? 1 : tier - 6;
    pick = $urandom_range(0, 3);
    if (tier == 0 && pick == 2) r.wcdma_present = 1'b1;
    if (tier == 0 && pick == 3) r.tdscdma_present = 1'b1;
    if (tier == 1) begin
      if (pick[0]) r.tdscdma_present = 1'b1;
      else r.wcdma_present = 1'b1;
    end
    r.gsm_rssi = pick_code(0, RSSI_TOP, tier == 0 && (pick == 0 || $urandom_range(0, 1) == 1));
    r.lte_rssi = pick_code(0, RSSI_TOP, tier == 0 && (pick == 1 || $urandom_range(0, 1) == 1));
    if (r.wcdma_present) begin
      r.wcdma_rssi = pick_code(0, RSSI_TOP,
                               tier == 0 && (pick == 2 || $urandom_range(0, 1) == 1));
      r.wcdma_rscp = pick_code(0, RSCP_TOP, (tier == 0) ? $urandom_range(0, 1) == 1 :
                               tier == 1 && (!pick[0] || $urandom_range(0, 1) == 1));
    end
    if (r.tdscdma_present) begin
      r.tdscdma_rssi = pick_code(0, RSSI_TOP,
                                 tier == 0 && (pick == 3 || $urandom_range(0, 1) == 1));
      r.tdscdma_rscp = pick_code(0, RSCP_TOP, (tier == 0) ? $urandom_range(0, 1) == 1 :
                                 tier == 1 && (pick[0] || $urandom_range(0, 1) == 1));
    end
    r.lte_rsrp = pick_code(RSRP_LOW, RSRP_HIGH,
                           tier == 2 || (tier < 2 && $urandom_range(0, 1) == 1));
    return r;
  endfunction

  function automatic int idle_span();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  task automatic note_error(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        strength_due.push_back(predict_strength(on_offer, weak_thr, strong_thr));
        offer_open = 1'b0;
      end
      if (!offer_open) begin
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (report_backlog.size() > 0) begin
          on_offer = report_backlog.pop_front();
          offer_open = 1'b1;
          in_ch.gsm_rssi        <= on_offer.gsm_rssi;
          in_ch.lte_rssi        <= on_offer.lte_rssi;
          in_ch.lte_rsrp        <= on_offer.lte_rsrp;
          in_ch.wcdma_present   <= on_offer.wcdma_present;
          in_ch.wcdma_rssi      <= on_offer.wcdma_rssi;
          in_ch.wcdma_rscp      <= on_offer.wcdma_rscp;
          in_ch.tdscdma_present <= on_offer.tdscdma_present;
          in_ch.tdscdma_rssi    <= on_offer.tdscdma_rssi;
          in_ch.tdscdma_rscp    <= on_offer.tdscdma_rscp;
          in_ch.valid           <= 1'b1;
          src_gap = (src_calm || $urandom_range(0, 2) != 0) ? 0 : idle_span();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    csp_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (strength_due.size() == 0) begin
          note_error("result with no request outstanding");
        end else begin
          want = strength_due.pop_front();
          if (out_ch.strength_dbm !== want.dbm)
            note_error($sformatf("strength_dbm %0d, expected %0d", out_ch.strength_dbm,
                                 want.dbm));
          if (out_ch.strength_percent !== want.pct)
            note_error($sformatf("strength_percent %0d, expected %0d",
                                 out_ch.strength_percent, want.pct));
          if (out_ch.measure_used !== want.used)
            note_error($sformatf("measure_used %0d, expected %0d", out_ch.measure_used,
                                 want.used));
        end
      end
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        sink_hold = $urandom_range(70, 100);
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ch.ready <= 1'b0;
      end else if (!sink_calm && $urandom_range(0, 4) == 0) begin
        sink_hold = idle_span() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int p;
    int k;
    int w;
    int s;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = CFG_WEAK;
    cfg_data              = '0;
    in_ch.valid           = 1'b0;
    in_ch.gsm_rssi        = '0;
    in_ch.lte_rssi        = '0;
    in_ch.lte_rsrp        = '0;
    in_ch.wcdma_present   = 1'b0;
    in_ch.wcdma_rssi      = '0;
    in_ch.wcdma_rscp      = '0;
    in_ch.tdscdma_present = 1'b0;
    in_ch.tdscdma_rssi    = '0;
    in_ch.tdscdma_rscp    = '0;
    out_ch.ready          = 1'b0;
    weak_thr              = WEAK_RESET;
    strong_thr            = STRONG_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    report_backlog.push_back(mk_report(0, 0, 0, 0, 0, 0, 0, 0, 0));
    report_backlog.push_back(mk_report(31, NO_CODE, NO_CODE, 0, NO_CODE, NO_CODE, 0, NO_CODE,
                                       NO_CODE));
    report_backlog.push_back(mk_report(NO_CODE, 31, NO_CODE, 0, 0, 0, 0, 0, 0));
    report_backlog.push_back(mk_report(32, 32, 43, 0, 5, 5, 0, 5, 5));
    report_backlog.push_back(mk_report(NO_CODE, NO_CODE, 141, 0, 0, 0, 0, 0, 0));
    report_backlog.push_back(mk_report(NO_CODE, NO_CODE, 44, 0, 0, 0, 0, 0, 0));
    report_backlog.push_back(mk_report(NO_CODE, NO_CODE, 140, 0, 0, 0, 0, 0, 0));
    report_backlog.push_back(mk_report(NO_CODE, NO_CODE, 100, 0, 0, 0, 0, 0, 0));
    report_backlog.push_back(mk_report(NO_CODE, NO_CODE, 99, 0, 0, 0, 0, 0, 0));
    report_backlog.push_back(mk_report(NO_CODE, NO_CODE, 61, 0, 0, 0, 0, 0, 0));
    report_backlog.push_back(mk_report(NO_CODE, NO_CODE, 60, 0, 0, 0, 0, 0, 0));
    report_backlog.push_back(mk_report(NO_CODE, NO_CODE, NO_CODE, 1, 20, NO_CODE, 0, 0, 0));
    report_backlog.push_back(mk_report(NO_CODE, NO_CODE, 70, 0, 31, 96, 0, 31, 96));
    report_backlog.push_back(mk_report(NO_CODE, NO_CODE, 70, 1, 32, 96, 0, 31, 0));
    report_backlog.push_back(mk_report(NO_CODE, NO_CODE, NO_CODE, 1, NO_CODE, 0, 0, 0, 0));
    report_backlog.push_back(mk_report(NO_CODE, NO_CODE, NO_CODE, 1, NO_CODE, 97, 1,
                                       NO_CODE, 50));
    report_backlog.push_back(mk_report(5, NO_CODE, NO_CODE, 0, NO_CODE, NO_CODE, 1, 31,
                                       NO_CODE));
    report_backlog.push_back(mk_report(NO_CODE, NO_CODE, 44, 1, NO_CODE, NO_CODE, 1,
                                       NO_CODE, NO_CODE));
    report_backlog.push_back(mk_report(NO_CODE, NO_CODE, NO_CODE, 1, NO_CODE, 30, 1,
                                       NO_CODE, 60));
    report_backlog.push_back(mk_report(3, 10, NO_CODE, 1, 7, NO_CODE, 0, 31, 0));
    report_backlog.push_back(mk_report(NO_CODE, NO_CODE, NO_CODE, 1, NO_CODE, NO_CODE, 1,
                                       NO_CODE, NO_CODE));
    report_backlog.push_back(mk_report(31, 31, 140, 1, 31, 96, 1, 31, 96));
    report_backlog.push_back(mk_report(NO_CODE, NO_CODE, 0, 1, NO_CODE, NO_CODE, 1, NO_CODE,
                                       NO_CODE));

    for (p = 0; p < PHASES; p++) begin
      while (report_backlog.size() != 0 || offer_open || strength_due.size() != 0)
        @(posedge clk);
      if (p > 0) begin
        case (p)
          1: begin w = -140; s = 0;    end
          2: begin w = 0;    s = -140; end
          3: begin w = -113; s = -51;  end
          4: begin w = -256; s = 255;  end
          5: begin w = 255;  s = -256; end
          6: begin w = -80;  s = -80;  end
          7: begin w = -120; s = -24;  end
          default: begin
            w = -$urandom_range(60, 140);
            s = -$urandom_range(0, 59);
          end
        endcase
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WEAK;
        cfg_data <= w[DBM_W-1:0];
        @(posedge clk);
        cfg_idx  <= CFG_STRONG;
        cfg_data <= s[DBM_W-1:0];
        @(posedge clk);
        cfg_we     <= 1'b0;
        weak_thr   = w[DBM_W-1:0];
        strong_thr = s[DBM_W-1:0];
      end
      src_calm  = (p % 3 == 1) || (p == SQUEEZE_PHASE);
      sink_calm = (p % 3 == 1);
      if (p == SQUEEZE_PHASE) squeeze_req = 1'b1;
      for (k = 0; k < PHASE_REPORTS; k++) report_backlog.push_back(rand_report());
    end

    while (report_backlog.size() != 0 || offer_open || strength_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
